// ===== rtl/fpa_pkg.sv =====
// Shared types and codes for the fixed-partition first-fit allocator.
// Used by fpa_cfg, fpa_ctrl and the top level; depends on nothing.
package fpa_pkg;

	localparam int TOTAL_W   = 23;
	localparam int REQ_W     = 20;
	localparam int PID_W     = 16;
	localparam int COUNT_W   = 4;
	localparam int IDX_W     = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;
	localparam logic [TOTAL_W-1:0] LIMIT_RESET = 23'd1024;

	localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEM_LIMIT  = 1'b1;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_ALLOC = 2'd1,
		MODE_FREE  = 2'd2,
		MODE_QUERY = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_NOFIT  = 3'd1,
		ST_NOID   = 3'd2,
		ST_LIMIT  = 3'd3,
		ST_BADIDX = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [COUNT_W-1:0] part_count;
		logic [TOTAL_W-1:0] mem_limit;
	} cfg_t;

	typedef struct packed {
		mode_t            mode;
		logic [IDX_W-1:0] index;
		logic [REQ_W-1:0] request_size;
		logic [PID_W-1:0] process_id;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic [IDX_W-1:0]   partition_index;
		logic               found_busy;
		logic [PID_W-1:0]   owner;
		logic [REQ_W-1:0]   part_length;
		logic [TOTAL_W-1:0] total_in_use;
	} result_t;

endpackage

// ===== rtl/fpa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on nothing.
module fpa_ram #(
	parameter int WIDTH = 37,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/fpa_cfg.sv =====
// Configuration registers: partition count and memory limit.
// Depends on fpa_pkg.
module fpa_cfg
	import fpa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TOTAL_W-1:0]   cfg_data,
	output cfg_t                 cfg
);

	logic [COUNT_W-1:0] count_q;
	logic [TOTAL_W-1:0] limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PART_COUNT: count_q <= cfg_data[COUNT_W-1:0];
				CFG_MEM_LIMIT:  limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.part_count = count_q;
	assign cfg.mem_limit  = limit_q;

endmodule

// ===== rtl/fpa_ctrl.sv =====
// Sequencer for the allocator: partition table in fpa_ram, read-modify-write
// over one entry per cycle, running size total. Depends on fpa_pkg, fpa_ram.
module fpa_ctrl
	import fpa_pkg::*;
#(
	parameter int PARTITIONS = 8,
	parameter int SIZE_BITS  = 20
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	output logic    in_ready,
	input  item_t   item,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	localparam int AW    = PARTITIONS > 1 ? $clog2(PARTITIONS) : 1;
	localparam int EW    = SIZE_BITS + PID_W + 1;
	localparam int CW    = (AW > COUNT_W ? AW : COUNT_W) + 1;
	localparam int CMP_W = SIZE_BITS > REQ_W ? SIZE_BITS : REQ_W;
	localparam int SUM_RAW = SIZE_BITS + AW + 1;
	localparam int SUM_W = SUM_RAW > TOTAL_W + 1 ? SUM_RAW : TOTAL_W + 1;

	state_t              state_q, state_d;
	item_t               item_q;
	logic [COUNT_W-1:0]  n_q;
	logic [AW-1:0]       ptr_q, ptr_d;
	logic                found_q, found_d;
	result_t             res_q, res_d;
	logic [SUM_W-1:0]    sum_q, sum_d;
	logic [PARTITIONS-1:0] valid_q;

	logic                rd_en, wr_en;
	logic [AW-1:0]       rd_addr;
	logic [EW-1:0]       wr_data, rd_data, entry;
	logic [SIZE_BITS-1:0] e_size, new_size;
	logic [PID_W-1:0]    e_owner;
	logic                e_busy;
	logic [COUNT_W-1:0]  n_now;
	logic [TOTAL_W-1:0]  total_sat;
	logic                over, last, fit, hit, early_err;
	status_t             early_status;

	fpa_ram #(.WIDTH(EW), .DEPTH(PARTITIONS)) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (ptr_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Partitions in use and the saturated total
	assign n_now = (32'(cfg.part_count) > PARTITIONS) ? COUNT_W'(PARTITIONS) : cfg.part_count;
	assign total_sat = (sum_q > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_q[TOTAL_W-1:0];
	assign over = total_sat > cfg.mem_limit;

	// An entry never written reads as a free, empty partition
	assign entry    = valid_q[ptr_q] ? rd_data : '0;
	assign e_size   = entry[SIZE_BITS-1:0];
	assign e_owner  = entry[SIZE_BITS+PID_W-1:SIZE_BITS];
	assign e_busy   = entry[EW-1];
	assign new_size = SIZE_BITS'(item_q.request_size);
	assign last     = (CW'(ptr_q) + CW'(1)) == CW'(n_q);
	assign fit      = !e_busy && (CMP_W'(item_q.request_size) <= CMP_W'(e_size));
	assign hit      = e_busy && (e_owner == item_q.process_id);

	always_comb begin
		early_err    = 1'b0;
		early_status = ST_OK;
		case (item.mode)
			MODE_LOAD, MODE_QUERY: begin
				if (COUNT_W'(item.index) >= n_now) begin
					early_err    = 1'b1;
					early_status = ST_BADIDX;
				end
			end
			MODE_ALLOC, MODE_FREE: begin
				early_err = over || (n_now == '0);
				if (over) begin
					early_status = ST_LIMIT;
				end else if (item.mode == MODE_ALLOC) begin
					early_status = ST_NOFIT;
				end else begin
					early_status = ST_NOID;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		found_d   = found_q;
		res_d     = res_q;
		sum_d     = sum_q;
		rd_en     = 1'b0;
		rd_addr   = ptr_q;
		wr_en     = 1'b0;
		wr_data   = entry;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					rd_en   = 1'b1;
					rd_addr = (item.mode == MODE_LOAD || item.mode == MODE_QUERY) ?
						AW'(item.index) : '0;
					ptr_d   = rd_addr;
					found_d = 1'b0;
					res_d   = '0;
					if (early_err) begin
						res_d.status = early_status;
						state_d      = S_RESP;
					end else begin
						res_d.status = (item.mode == MODE_ALLOC) ? ST_NOFIT :
							(item.mode == MODE_FREE) ? ST_NOID : ST_OK;
						state_d      = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				case (item_q.mode)
					MODE_LOAD: begin
						wr_en   = 1'b1;
						wr_data = {e_busy, e_owner, new_size};
						sum_d   = sum_q - SUM_W'(e_size) + SUM_W'(new_size);
						res_d   = '{ST_OK, IDX_W'(ptr_q), e_busy, e_owner,
							REQ_W'(new_size), '0};
						state_d = S_RESP;
					end
					MODE_QUERY: begin
						res_d   = '{ST_OK, IDX_W'(ptr_q), e_busy, e_owner,
							REQ_W'(e_size), '0};
						state_d = S_RESP;
					end
					MODE_ALLOC: begin
						if (fit) begin
							wr_en   = 1'b1;
							wr_data = {1'b1, item_q.process_id, e_size};
							res_d   = '{ST_OK, IDX_W'(ptr_q), 1'b1, item_q.process_id,
								REQ_W'(e_size), '0};
							state_d = S_RESP;
						end else if (last) begin
							state_d = S_RESP;
						end else begin
							ptr_d   = ptr_q + AW'(1);
							rd_en   = 1'b1;
							rd_addr = ptr_d;
						end
					end
					MODE_FREE: begin
						if (hit) begin
							wr_en   = 1'b1;
							wr_data = {1'b0, {PID_W{1'b0}}, e_size};
							found_d = 1'b1;
							// report only the first partition released
							if (!found_q) begin
								res_d = '{ST_OK, IDX_W'(ptr_q), 1'b0, item_q.process_id,
									REQ_W'(e_size), '0};
							end
						end
						if (last) begin
							state_d = S_RESP;
						end else begin
							ptr_d   = ptr_q + AW'(1);
							rd_en   = 1'b1;
							rd_addr = ptr_d;
						end
					end
					default: state_d = S_RESP;
				endcase
			end
			S_RESP: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sum_q   <= '0;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			sum_q   <= sum_d;
			if (wr_en) begin
				valid_q[ptr_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= item;
			n_q    <= n_now;
		end
		ptr_q   <= ptr_d;
		found_q <= found_d;
		res_q   <= res_d;
	end

	always_comb begin
		res              = res_q;
		res.total_in_use = total_sat;
	end

	// Table writes happen only while an entry is under inspection
	a_wr_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == S_CHECK)
		else $error("table write outside the check state");

	// The scan pointer stays inside the partitions in use
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> CW'(ptr_q) < CW'(n_q))
		else $error("scan pointer beyond partitions in use");

	// A refused operation reports no partition contents
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status != ST_OK) |->
		(res.owner == '0 && res.part_length == '0 && !res.found_busy))
		else $error("failed result carries partition data");

	// A new item is taken only once the previous result has left the sequencer, and an accepted item moves it out of idle
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q != S_IDLE)
		else $error("accepted item did not start");

endmodule

// ===== rtl/fixed_partition_first_fit_allocator_core.sv =====
// Top level of the fixed-partition first-fit allocator: configuration,
// sequencer and output register. Depends on fpa_pkg, fpa_cfg, fpa_ctrl.
//
// Usage:
//   Input beats on s_* carry one command each: load a partition size, allocate
//   a process to the first free partition large enough, free every partition
//   held by an id, or query one partition. Each command gives exactly one
//   result beat on m_*, in order, with a status code and the partition report.
//   The cfg_* channel writes the partition count (index 0) and memory limit
//   (index 1); write it only while no command is in flight.
//   A load or a query inspects one partition and a refused command none; an
//   allocate or free inspects partitions in order, at most the partitions in
//   use. The partition table sits in one RAM with one read a cycle, so the
//   scan reads the partitions one by one, and the sequencer then hands the
//   result to the output register. The next command is taken the cycle after
//   that hand-over.
//   At reset the count is 8, the limit 1024 and every partition reads as free
//   and empty at once: per-entry valid flags clear on reset, with no sweep.
//   When the receiver stalls, the result waits in the output register; one
//   further command may be taken and worked on meanwhile, then the sequencer
//   holds its result until the output register frees.
module fixed_partition_first_fit_allocator_core
	import fpa_pkg::*;
#(
	parameter int PARTITIONS = 8,
	parameter int SIZE_BITS  = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// command channel
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [39:0]          s_tdata,  // index[2:0], request_size[22:3], process_id[38:23]
	input  logic [1:0]           s_tuser,  // mode[1:0]
	// result channel
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [63:0]          m_tdata,  // partition_index[2:0], found_busy[3], owner[19:4],
	                                       // part_length[39:20], total_in_use[62:40]
	output logic [2:0]           m_tuser,  // status[2:0]
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TOTAL_W-1:0]   cfg_data
);

	cfg_t    cfg;
	item_t   item;
	result_t res;
	logic    res_valid, res_ready;
	logic    m_valid_q;
	result_t m_res_q;

	fpa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Unpack the command beat
	assign item.mode         = mode_t'(s_tuser);
	assign item.index        = s_tdata[2:0];
	assign item.request_size = s_tdata[22:3];
	assign item.process_id   = s_tdata[38:23];

	fpa_ctrl #(.PARTITIONS(PARTITIONS), .SIZE_BITS(SIZE_BITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.item      (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: load when empty or being drained this cycle
	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_res_q.status;
	assign m_tdata  = {1'b0, m_res_q.total_in_use, m_res_q.part_length, m_res_q.owner,
		m_res_q.found_busy, m_res_q.partition_index};

endmodule
